// ----- rtl/spc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

  localparam int VAL_W     = 24;
  localparam int CORR_W    = 32;
  localparam int OUT_CNT_W = 11;
  localparam int FRAC_W    = 30;
  localparam int IN_USER_W = 2;
  localparam int OUT_DW    = ((CORR_W + OUT_CNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_DW - CORR_W - OUT_CNT_W;

  // Operand selection for the shared divider.
  localparam logic [1:0] DIV_SEL_MEAN_A = 2'd0;
  localparam logic [1:0] DIV_SEL_MEAN_B = 2'd1;
  localparam logic [1:0] DIV_SEL_CORR   = 2'd2;

  typedef struct packed {
    logic       load;
    logic       clear_cols;
    logic       mean_clear;
    logic       merge_clear;
    logic       merge_step;
    logic       mul_step;
    logic       acc_step;
    logic       div_start;
    logic [1:0] div_sel;
    logic       ma_load;
    logic       mb_load;
    logic       prod_start;
    logic       sqrt_start;
    logic       fin;
  } spc_cmd_t;

  typedef struct packed {
    logic ptr_ok;
    logic row_eq;
    logic div_done;
    logic prod_done;
    logic sqrt_done;
  } spc_stat_t;

endpackage

`default_nettype wire

// ----- rtl/spc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spc_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/spc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module spc_div #(
  parameter int DW = 93,
  parameter int VW = 63
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic      [DW-1:0] quotient,
  output logic      [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] qr_r,  qr_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   rem_sh;
  logic          ge;

  always_comb begin
    rem_sh  = {rem_r, qr_r[DW-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? VW'(rem_sh - {1'b0, dvs_r}) : rem_sh[VW-1:0];
    qr_nxt  = {qr_r[DW-2:0], ge};
    cnt_nxt = cnt_r - CW'(1);
    done_nxt = (cnt_r == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(DW);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      qr_r  <= qr_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = qr_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ----- rtl/spc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spc_dp
  import spc_pkg::*;
#(
  parameter int COLUMN_DEPTH = 1024,
  parameter int ROW_BITS     = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire spc_cmd_t              cmd,
  output spc_stat_t                  stat,
  input  wire logic                  mean_over_all,
  input  wire logic                  mode,
  input  wire logic [ROW_BITS-1:0]   row_index,
  input  wire logic [VAL_W-1:0]      value,
  input  wire logic                  entry_valid,
  output logic      [CORR_W-1:0]     correlation,
  output logic      [OUT_CNT_W-1:0]  common_count
);

  localparam int CNT_W  = $clog2(COLUMN_DEPTH + 1);
  localparam int ADDR_W = $clog2(COLUMN_DEPTH);
  localparam int ENT_W  = ROW_BITS + VAL_W;
  localparam int SUM_W  = VAL_W + CNT_W;
  localparam int MEAN_W = VAL_W + 1;
  localparam int DEV_W  = VAL_W + 2;
  localparam int PROD_W = 2 * DEV_W;
  localparam int ACC_W  = PROD_W + CNT_W;
  localparam int PW     = 2 * ACC_W;
  localparam int DIV_W  = ACC_W + FRAC_W;
  localparam int ST_W   = $clog2(ACC_W + 1);

  // Column loading
  logic [CNT_W-1:0]        count_a_r, count_b_r;
  logic signed [SUM_W-1:0] sum_a_r, sum_b_r;
  logic                    we_a, we_b;
  logic [ENT_W-1:0]        rdata_a, rdata_b;

  // Merge walk
  logic [CNT_W-1:0]         p_r, q_r, mcnt_r;
  logic signed [SUM_W-1:0]  msa_r, msb_r;
  logic [ROW_BITS-1:0]      ra, rb;
  logic signed [VAL_W-1:0]  va, vb;
  logic signed [MEAN_W-1:0] ma_r, mb_r, ma_nxt, mb_nxt;
  logic signed [DEV_W-1:0]  dva_r, dvb_r;
  logic signed [PROD_W-1:0] pnum_r, pda_r, pdb_r;
  logic signed [ACC_W-1:0]  num_r, da_r, db_r;

  // Divider operands
  logic signed [SUM_W-1:0] sa_src, sb_src, s_sel;
  logic [CNT_W-1:0]        na_src, nb_src, n_sel;
  logic [SUM_W-1:0]        s_mag;
  logic [ACC_W-1:0]        num_mag;
  logic [DIV_W-1:0]        div_dividend, quot;
  logic [ACC_W-1:0]        div_divisor, rem;
  logic                    div_done;

  // Serial product and square root
  logic [PW-1:0]    prod_r, rad_r;
  logic [ST_W-1:0]  prod_cnt_r, sq_cnt_r;
  logic             prod_done_r, sqrt_done_r;
  logic [ACC_W:0]   prod_sum;
  logic [ACC_W-1:0] root_r;
  logic [ACC_W:0]   sqrem_r;
  logic [ACC_W+2:0] sq_sh, sq_trial;
  logic             sq_ge;

  // Result
  logic [CORR_W-1:0] qv, q1, qs;
  logic              rnd;
  logic [CORR_W-1:0] corr_r;
  logic [OUT_CNT_W-1:0] ccnt_r;

  localparam logic [CORR_W-1:0] ONE_Q = CORR_W'(1) << FRAC_W;

  assign we_a = cmd.load && entry_valid && !mode && (count_a_r != CNT_W'(COLUMN_DEPTH));
  assign we_b = cmd.load && entry_valid && mode && (count_b_r != CNT_W'(COLUMN_DEPTH));

  spc_ram #(.WIDTH(ENT_W), .DEPTH(COLUMN_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a_r[ADDR_W-1:0]),
    .wdata ({value, row_index}),
    .raddr (p_r[ADDR_W-1:0]),
    .rdata (rdata_a)
  );

  spc_ram #(.WIDTH(ENT_W), .DEPTH(COLUMN_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b_r[ADDR_W-1:0]),
    .wdata ({value, row_index}),
    .raddr (q_r[ADDR_W-1:0]),
    .rdata (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_cols) begin
      count_a_r <= '0;
      count_b_r <= '0;
      sum_a_r   <= '0;
      sum_b_r   <= '0;
    end else begin
      if (we_a) begin
        count_a_r <= count_a_r + CNT_W'(1);
        sum_a_r   <= sum_a_r + {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};
      end
      if (we_b) begin
        count_b_r <= count_b_r + CNT_W'(1);
        sum_b_r   <= sum_b_r + {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};
      end
    end
  end

  assign ra = rdata_a[ROW_BITS-1:0];
  assign rb = rdata_b[ROW_BITS-1:0];
  assign va = rdata_a[ENT_W-1:ROW_BITS];
  assign vb = rdata_b[ENT_W-1:ROW_BITS];

  // The merge pointers are also cleared with the columns so that they never
  // point past a column that is being reloaded.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.merge_clear || cmd.clear_cols) begin
      p_r    <= '0;
      q_r    <= '0;
      mcnt_r <= '0;
      msa_r  <= '0;
      msb_r  <= '0;
    end else if (cmd.merge_step) begin
      if (ra == rb) begin
        p_r    <= p_r + CNT_W'(1);
        q_r    <= q_r + CNT_W'(1);
        mcnt_r <= mcnt_r + CNT_W'(1);
        msa_r  <= msa_r + {{(SUM_W-VAL_W){va[VAL_W-1]}}, va};
        msb_r  <= msb_r + {{(SUM_W-VAL_W){vb[VAL_W-1]}}, vb};
      end else if (ra > rb) begin
        q_r <= q_r + CNT_W'(1);
      end else begin
        p_r <= p_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.merge_step) begin
      dva_r <= {{2{va[VAL_W-1]}}, va} - {ma_r[MEAN_W-1], ma_r};
      dvb_r <= {{2{vb[VAL_W-1]}}, vb} - {mb_r[MEAN_W-1], mb_r};
    end
    if (cmd.mul_step) begin
      pnum_r <= dva_r * dvb_r;
      pda_r  <= dva_r * dva_r;
      pdb_r  <= dvb_r * dvb_r;
    end
    if (cmd.merge_clear) begin
      num_r <= '0;
      da_r  <= '0;
      db_r  <= '0;
    end else if (cmd.acc_step) begin
      num_r <= num_r + {{CNT_W{pnum_r[PROD_W-1]}}, pnum_r};
      da_r  <= da_r + {{CNT_W{pda_r[PROD_W-1]}}, pda_r};
      db_r  <= db_r + {{CNT_W{pdb_r[PROD_W-1]}}, pdb_r};
    end
  end

  // Mean sources follow the mode register; the user must change it only while idle, the block does not enforce this.
  always_comb begin
    sa_src = mean_over_all ? sum_a_r : msa_r;
    na_src = mean_over_all ? count_a_r : mcnt_r;
    sb_src = mean_over_all ? sum_b_r : msb_r;
    nb_src = mean_over_all ? count_b_r : mcnt_r;
    s_sel  = (cmd.div_sel == DIV_SEL_MEAN_B) ? sb_src : sa_src;
    n_sel  = (cmd.div_sel == DIV_SEL_MEAN_B) ? nb_src : na_src;
    s_mag  = s_sel[SUM_W-1] ? SUM_W'(-s_sel) : SUM_W'(s_sel);
    num_mag = num_r[ACC_W-1] ? ACC_W'(-num_r) : ACC_W'(num_r);
    if (cmd.div_sel == DIV_SEL_CORR) begin
      div_dividend = {num_mag, {FRAC_W{1'b0}}};
      div_divisor  = root_r;
    end else begin
      // Half away from zero: (2|S| + n) / 2n.
      div_dividend = DIV_W'({s_mag, 1'b0}) + DIV_W'(n_sel);
      div_divisor  = ACC_W'({n_sel, 1'b0});
    end
  end

  spc_div #(.DW(DIV_W), .VW(ACC_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  always_comb begin
    if (na_src == '0) begin
      ma_nxt = '0;
    end else if (sa_src[SUM_W-1]) begin
      ma_nxt = -$signed(quot[MEAN_W-1:0]);
    end else begin
      ma_nxt = $signed(quot[MEAN_W-1:0]);
    end
    if (nb_src == '0) begin
      mb_nxt = '0;
    end else if (sb_src[SUM_W-1]) begin
      mb_nxt = -$signed(quot[MEAN_W-1:0]);
    end else begin
      mb_nxt = $signed(quot[MEAN_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_clear) begin
      ma_r <= '0;
      mb_r <= '0;
    end else begin
      if (cmd.ma_load) ma_r <= ma_nxt;
      if (cmd.mb_load) mb_r <= mb_nxt;
    end
  end

  // Shift-and-add product of the two deviation energies.
  assign prod_sum = prod_r[0] ? ({1'b0, prod_r[PW-1:ACC_W]} + {1'b0, da_r})
                              : {1'b0, prod_r[PW-1:ACC_W]};

  // Digit-by-digit square root, one root bit per cycle.
  always_comb begin
    sq_sh    = {sqrem_r, rad_r[PW-1:PW-2]};
    sq_trial = {1'b0, root_r, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_cnt_r  <= '0;
      sq_cnt_r    <= '0;
      prod_done_r <= 1'b0;
      sqrt_done_r <= 1'b0;
    end else begin
      if (cmd.prod_start) begin
        prod_cnt_r  <= ST_W'(ACC_W);
        prod_done_r <= 1'b0;
      end else if (prod_cnt_r != '0) begin
        prod_cnt_r  <= prod_cnt_r - ST_W'(1);
        prod_done_r <= (prod_cnt_r == ST_W'(1));
      end else begin
        prod_done_r <= 1'b0;
      end
      if (cmd.sqrt_start) begin
        sq_cnt_r    <= ST_W'(ACC_W);
        sqrt_done_r <= 1'b0;
      end else if (sq_cnt_r != '0) begin
        sq_cnt_r    <= sq_cnt_r - ST_W'(1);
        sqrt_done_r <= (sq_cnt_r == ST_W'(1));
      end else begin
        sqrt_done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_start) begin
      prod_r <= {{ACC_W{1'b0}}, db_r};
    end else if (prod_cnt_r != '0) begin
      prod_r <= {prod_sum, prod_r[ACC_W-1:1]};
    end
    if (cmd.sqrt_start) begin
      rad_r   <= prod_r;
      root_r  <= '0;
      sqrem_r <= '0;
    end else if (sq_cnt_r != '0) begin
      rad_r   <= {rad_r[PW-3:0], 2'b00};
      root_r  <= {root_r[ACC_W-2:0], sq_ge};
      sqrem_r <= sq_ge ? (ACC_W+1)'(sq_sh - sq_trial) : sq_sh[ACC_W:0];
    end
  end

  always_comb begin
    qv  = quot[CORR_W-1:0];
    rnd = {rem, 1'b0} >= {1'b0, root_r};
    q1  = qv + CORR_W'(rnd);
    qs  = (q1 > ONE_Q) ? ONE_Q : q1;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (da_r == '0 || db_r == '0) begin
        corr_r <= '0;
      end else begin
        corr_r <= num_r[ACC_W-1] ? -qs : qs;
      end
      ccnt_r <= OUT_CNT_W'(mcnt_r);
    end
  end

  assign correlation  = corr_r;
  assign common_count = ccnt_r;

  assign stat.ptr_ok    = (p_r < count_a_r) && (q_r < count_b_r);
  assign stat.row_eq    = (ra == rb);
  assign stat.div_done  = div_done;
  assign stat.prod_done = prod_done_r;
  assign stat.sqrt_done = sqrt_done_r;

  a_p_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    p_r <= count_a_r || count_a_r == '0)
    else $error("merge pointer A beyond column A");
  a_q_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    q_r <= count_b_r || count_b_r == '0)
    else $error("merge pointer B beyond column B");
  a_common_le_p : assert property (@(posedge clk) disable iff (!rst_n)
    mcnt_r <= p_r && mcnt_r <= q_r)
    else $error("common count exceeds merge pointers");

endmodule

`default_nettype wire

// ----- rtl/spc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spc_ctrl
  import spc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      mean_over_all,
  input  wire logic      in_accept,
  input  wire logic      in_is_b,
  input  wire logic      in_last,
  input  wire logic      out_taken,
  input  wire spc_stat_t stat,
  output spc_cmd_t       cmd,
  output logic           in_ready,
  output logic           out_valid
);

  localparam logic [4:0] S_LOAD  = 5'd0;
  localparam logic [4:0] S_MINIT = 5'd1;
  localparam logic [4:0] S_MRD   = 5'd2;
  localparam logic [4:0] S_MCMP  = 5'd3;
  localparam logic [4:0] S_MMUL  = 5'd4;
  localparam logic [4:0] S_MACC  = 5'd5;
  localparam logic [4:0] S_MA    = 5'd6;
  localparam logic [4:0] S_MAW   = 5'd7;
  localparam logic [4:0] S_MB    = 5'd8;
  localparam logic [4:0] S_MBW   = 5'd9;
  localparam logic [4:0] S_PROD  = 5'd10;
  localparam logic [4:0] S_PRODW = 5'd11;
  localparam logic [4:0] S_SQRT  = 5'd12;
  localparam logic [4:0] S_SQRTW = 5'd13;
  localparam logic [4:0] S_DIV   = 5'd14;
  localparam logic [4:0] S_DIVW  = 5'd15;
  localparam logic [4:0] S_FIN   = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic       pass2_r, pass2_nxt;

  always_comb begin
    state_nxt = state_r;
    pass2_nxt = pass2_r;
    cmd       = '0;
    cmd.load  = in_accept;
    case (state_r)
      S_LOAD: begin
        if (in_accept && in_is_b && in_last) begin
          cmd.mean_clear = 1'b1;
          // With means over all entries the first merge pass is not needed.
          pass2_nxt = mean_over_all;
          state_nxt = mean_over_all ? S_MA : S_MINIT;
        end
      end
      S_MINIT: begin
        cmd.merge_clear = 1'b1;
        state_nxt = S_MRD;
      end
      S_MRD: begin
        if (!stat.ptr_ok) begin
          if (pass2_r) begin
            state_nxt = S_PROD;
          end else begin
            pass2_nxt = 1'b1;
            state_nxt = S_MA;
          end
        end else begin
          state_nxt = S_MCMP;
        end
      end
      S_MCMP: begin
        cmd.merge_step = 1'b1;
        state_nxt = stat.row_eq ? S_MMUL : S_MRD;
      end
      S_MMUL: begin
        cmd.mul_step = 1'b1;
        state_nxt = S_MACC;
      end
      S_MACC: begin
        cmd.acc_step = 1'b1;
        state_nxt = S_MRD;
      end
      S_MA: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_MEAN_A;
        state_nxt = S_MAW;
      end
      S_MAW: begin
        cmd.div_sel = DIV_SEL_MEAN_A;
        if (stat.div_done) begin
          cmd.ma_load = 1'b1;
          state_nxt = S_MB;
        end
      end
      S_MB: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_MEAN_B;
        state_nxt = S_MBW;
      end
      S_MBW: begin
        cmd.div_sel = DIV_SEL_MEAN_B;
        if (stat.div_done) begin
          cmd.mb_load = 1'b1;
          state_nxt = S_MINIT;
        end
      end
      S_PROD: begin
        cmd.prod_start = 1'b1;
        state_nxt = S_PRODW;
      end
      S_PRODW: begin
        if (stat.prod_done) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_start = 1'b1;
        state_nxt = S_SQRTW;
      end
      S_SQRTW: begin
        if (stat.sqrt_done) state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_CORR;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        cmd.div_sel = DIV_SEL_CORR;
        if (stat.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.div_sel = DIV_SEL_CORR;
        cmd.fin = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_taken) begin
          cmd.clear_cols = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      pass2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass2_r <= pass2_nxt;
    end
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT);

  a_ready_valid_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");
  a_back_to_load : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_taken |=> in_ready)
    else $error("block did not return to loading after the result transfer");
  a_result_after_fin : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_FIN))
    else $error("result shown without final computation");

endmodule

`default_nettype wire

// ----- rtl/sparse_pearson_correlation.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sparse Pearson correlation of two columns. Column A entries, then column B
// entries, stream in at one transfer per cycle; the transfer that carries
// tlast for column B starts the computation and the input stalls until the
// single result (Q2.30 correlation, common-row count) has been taken. The
// computation consists of the merge walk over both column memories (two
// passes when cfg mean_over_all is 0, one otherwise) and, on three
// bit-serial units with one shared divider, two rounded-mean divisions, a
// shift-add product and a square root of ACC_W bits and a final division,
// where ACC_W = 2*26 + clog2(COLUMN_DEPTH+1), i.e. 63 by default.
// Entries beyond COLUMN_DEPTH per column are dropped.
module sparse_pearson_correlation
  import spc_pkg::*;
#(
  parameter int COLUMN_DEPTH = 1024,
  parameter int ROW_BITS     = 20
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data,  // mean_over_all
  input  wire logic in_tvalid,
  output logic      in_tready,
  // row_index, value, zero padding
  input  wire logic [((ROW_BITS + VAL_W + 7) / 8) * 8 - 1:0] in_tdata,
  input  wire logic [IN_USER_W-1:0] in_tuser,  // mode, entry_valid
  input  wire logic in_tlast,
  output logic      out_tvalid,
  input  wire logic out_tready,
  output logic [OUT_DW-1:0] out_tdata  // correlation, common_count, zero padding
);

  logic                 mean_over_all_r;
  logic                 in_accept;
  logic                 out_taken;
  spc_cmd_t             cmd;
  spc_stat_t            stat;
  logic [CORR_W-1:0]    correlation;
  logic [OUT_CNT_W-1:0] common_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_over_all_r <= 1'b1;
    end else if (cfg_wr_en) begin
      mean_over_all_r <= cfg_wr_data;
    end
  end

  assign in_accept = in_tvalid && in_tready;
  assign out_taken = out_tvalid && out_tready;

  spc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .mean_over_all (mean_over_all_r),
    .in_accept     (in_accept),
    .in_is_b       (in_tuser[0]),
    .in_last       (in_tlast),
    .out_taken     (out_taken),
    .stat          (stat),
    .cmd           (cmd),
    .in_ready      (in_tready),
    .out_valid     (out_tvalid)
  );

  spc_dp #(.COLUMN_DEPTH(COLUMN_DEPTH), .ROW_BITS(ROW_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .mean_over_all (mean_over_all_r),
    .mode          (in_tuser[0]),
    .row_index     (in_tdata[ROW_BITS-1:0]),
    .value         (in_tdata[ROW_BITS+VAL_W-1:ROW_BITS]),
    .entry_valid   (in_tuser[1]),
    .correlation   (correlation),
    .common_count  (common_count)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, common_count, correlation};

endmodule

`default_nettype wire
